// ===== sv/sbw_pkg.sv =====
`timescale 1ns / 1ps

package sbw_pkg;

	localparam int TIME_W  = 63;
	localparam int WATER_W = 48;
	localparam int IFB_W   = 24;
	localparam int QEB_W   = 16;
	localparam int CNT_IN_W = 16;
	localparam int OUT_STAT_W = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_PROGRESS = 2'd1;
	localparam logic [1:0] ACT_QUERY    = 2'd2;

	localparam logic [1:0] CLR_NONE     = 2'd0;
	localparam logic [1:0] CLR_PROGRESS = 2'd1;
	localparam logic [1:0] CLR_COOLDOWN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STALL_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REJ_WINDOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IFB        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QEB        = 3'd5;

	localparam logic [TIME_W-1:0]  RST_STALL_THR  = 63'd60000000000;
	localparam logic [TIME_W-1:0]  RST_REJ_WINDOW = 63'd30000000000;
	localparam logic [WATER_W-1:0] RST_LOW_WATER  = 48'd67108864;
	localparam logic [WATER_W-1:0] RST_HIGH_WATER = 48'd134217728;
	localparam logic [IFB_W-1:0]   RST_IFB        = 24'd1048576;
	localparam logic [QEB_W-1:0]   RST_QEB        = 16'd64;

	typedef struct packed {
		logic                  active_now;
		logic                  reject;
		logic                  drain_request;
		logic [1:0]            clear_reason;
		logic [TIME_W-1:0]     held_ns;
		logic                  armed_now;
		logic [OUT_STAT_W-1:0] entered_total;
		logic [OUT_STAT_W-1:0] cleared_total;
		logic [OUT_STAT_W-1:0] rejected_total;
	} rsp_t;

endpackage

// ===== sv/sbw_cfg_if.sv =====
`timescale 1ns / 1ps

interface sbw_cfg_if;
	import sbw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIME_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== sv/sbw_cmd_if.sv =====
`timescale 1ns / 1ps

interface sbw_cmd_if;
	import sbw_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [TIME_W-1:0]   timestamp;
	logic [CNT_IN_W-1:0] in_flight_count;
	logic [CNT_IN_W-1:0] queued_count;
	logic                block_work_cmd;

	modport source(output valid, output action, output timestamp, output in_flight_count,
		output queued_count, output block_work_cmd, input ready);
	modport sink(input valid, input action, input timestamp, input in_flight_count,
		input queued_count, input block_work_cmd, output ready);
endinterface

// ===== sv/sbw_rsp_if.sv =====
`timescale 1ns / 1ps

interface sbw_rsp_if;
	import sbw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  active_now;
	logic                  reject;
	logic                  drain_request;
	logic [1:0]            clear_reason;
	logic [TIME_W-1:0]     held_ns;
	logic                  armed_now;
	logic [OUT_STAT_W-1:0] entered_total;
	logic [OUT_STAT_W-1:0] cleared_total;
	logic [OUT_STAT_W-1:0] rejected_total;

	modport source(output valid, output active_now, output reject, output drain_request,
		output clear_reason, output held_ns, output armed_now, output entered_total,
		output cleared_total, output rejected_total, input ready);
	modport sink(input valid, input active_now, input reject, input drain_request,
		input clear_reason, input held_ns, input armed_now, input entered_total,
		input cleared_total, input rejected_total, output ready);
endinterface

// ===== sv/stall_backpressure_watchdog.sv =====
`timescale 1ns / 1ps

// Backpressure watchdog: takes one item per clock while its results are taken,
// and returns one result per item. The first stage registers the item together with its
// backlog estimate (two multiplies on the counts); the second stage updates the
// watchdog state and loads the result register. Since the state is read and written
// only in the second stage, items follow each other at the full clock rate; the
// output register lets a new item enter while a result still waits to be taken.
// Configuration writes are taken in any cycle and must only happen while idle.
module stall_backpressure_watchdog #(
	parameter int COUNT_WIDTH = 16,
	parameter int STAT_WIDTH  = 32
) (
	input logic        clk,
	input logic        arst_n,
	sbw_cfg_if.sink    cfg,
	sbw_cmd_if.sink    cmd,
	sbw_rsp_if.source  rsp
);
	import sbw_pkg::*;

	localparam int CW    = (COUNT_WIDTH < CNT_IN_W) ? COUNT_WIDTH : CNT_IN_W;
	localparam int BYTES_W = CW + IFB_W + 1;
	localparam int CMP_W = (BYTES_W > WATER_W) ? BYTES_W : WATER_W;

	// Configuration registers
	logic [TIME_W-1:0]  stall_thr_q;
	logic [TIME_W-1:0]  rej_window_q;
	logic [WATER_W-1:0] low_water_q;
	logic [WATER_W-1:0] hi_mark_q;
	logic [IFB_W-1:0]   ifb_q;
	logic [QEB_W-1:0]   qeb_q;

	// Watchdog state
	logic [TIME_W-1:0]     last_prog_q;
	logic [TIME_W-1:0]     entry_time_q;
	logic                  active_q;
	logic                  armed_q;
	logic [STAT_WIDTH-1:0] entry_cnt_q;
	logic [STAT_WIDTH-1:0] exit_cnt_q;
	logic [STAT_WIDTH-1:0] rej_cnt_q;

	// First stage
	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [TIME_W-1:0]  time_s1;
	logic               block_s1;
	logic [BYTES_W-1:0] bytes_s1;

	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic   adv;
	logic [BYTES_W-1:0] bytes_in;

	assign cfg.ready = 1'b1;
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	assign bytes_in = BYTES_W'(cmd.in_flight_count[CW-1:0] * ifb_q)
		+ BYTES_W'(cmd.queued_count[CW-1:0] * qeb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_thr_q  <= RST_STALL_THR;
			rej_window_q <= RST_REJ_WINDOW;
			low_water_q  <= RST_LOW_WATER;
			hi_mark_q    <= RST_HIGH_WATER;
			ifb_q        <= RST_IFB;
			qeb_q        <= RST_QEB;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STALL_THR:  stall_thr_q  <= cfg.data;
				REG_REJ_WINDOW: rej_window_q <= cfg.data;
				REG_LOW_WATER:  low_water_q  <= cfg.data[WATER_W-1:0];
				REG_HIGH_WATER: hi_mark_q    <= cfg.data[WATER_W-1:0];
				REG_IFB:        ifb_q        <= cfg.data[IFB_W-1:0];
				REG_QEB:        qeb_q        <= cfg.data[QEB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			time_s1   <= cmd.timestamp;
			block_s1  <= cmd.block_work_cmd;
			bytes_s1  <= bytes_in;
		end
	end

	// Second stage: state update
	logic                  ahead;
	logic                  after_entry;
	logic [TIME_W-1:0]     since;
	logic [TIME_W-1:0]     active_span;
	logic [CMP_W-1:0]      bytes_x;
	logic                  arm_tick;
	logic                  active_d;
	logic                  armed_d;
	logic [TIME_W-1:0]     last_prog_d;
	logic [TIME_W-1:0]     entry_time_d;
	logic [STAT_WIDTH-1:0] entry_cnt_d;
	logic [STAT_WIDTH-1:0] exit_cnt_d;
	logic [STAT_WIDTH-1:0] rej_cnt_d;
	logic                  reject_d;
	logic                  drain_d;
	logic [1:0]            reason_d;
	logic [TIME_W-1:0]     held_d;

	assign ahead       = time_s1 >= last_prog_q;
	assign after_entry = time_s1 >= entry_time_q;
	assign since       = time_s1 - last_prog_q;
	assign active_span = time_s1 - entry_time_q;
	assign bytes_x     = CMP_W'(bytes_s1);
	assign arm_tick    = armed_q || (bytes_x < CMP_W'(low_water_q));

	always_comb begin
		active_d     = active_q;
		armed_d      = armed_q;
		last_prog_d  = last_prog_q;
		entry_time_d = entry_time_q;
		entry_cnt_d  = entry_cnt_q;
		exit_cnt_d   = exit_cnt_q;
		rej_cnt_d    = rej_cnt_q;
		reject_d     = 1'b0;
		drain_d      = 1'b0;
		reason_d     = CLR_NONE;
		held_d       = '0;
		case (action_s1)
			ACT_TICK: begin
				if (!active_q) begin
					armed_d = arm_tick;
					if (ahead && since > stall_thr_q
						&& bytes_x > CMP_W'(hi_mark_q) && arm_tick) begin
						active_d     = 1'b1;
						armed_d      = 1'b0;
						entry_time_d = time_s1;
						entry_cnt_d  = entry_cnt_q + 1'b1;
						drain_d      = 1'b1;
					end
				end else begin
					if (!ahead || since < stall_thr_q) begin
						reason_d = CLR_PROGRESS;
					end else if (after_entry && active_span >= rej_window_q) begin
						reason_d = CLR_COOLDOWN;
					end
					if (reason_d != CLR_NONE) begin
						active_d   = 1'b0;
						exit_cnt_d = exit_cnt_q + 1'b1;
						held_d     = after_entry ? active_span : '0;
					end
				end
			end
			ACT_PROGRESS: begin
				last_prog_d = time_s1;
			end
			ACT_QUERY: begin
				if (active_q && block_s1) begin
					reject_d  = 1'b1;
					rej_cnt_d = rej_cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_prog_q  <= '0;
			entry_time_q <= '0;
			active_q     <= 1'b0;
			armed_q      <= 1'b1;
			entry_cnt_q  <= '0;
			exit_cnt_q   <= '0;
			rej_cnt_q    <= '0;
		end else if (adv) begin
			last_prog_q  <= last_prog_d;
			entry_time_q <= entry_time_d;
			active_q     <= active_d;
			armed_q      <= armed_d;
			entry_cnt_q  <= entry_cnt_d;
			exit_cnt_q   <= exit_cnt_d;
			rej_cnt_q    <= rej_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.active_now     <= active_d;
			rsp_q.reject         <= reject_d;
			rsp_q.drain_request  <= drain_d;
			rsp_q.clear_reason   <= reason_d;
			rsp_q.held_ns        <= held_d;
			rsp_q.armed_now      <= armed_d;
			rsp_q.entered_total  <= OUT_STAT_W'(entry_cnt_d);
			rsp_q.cleared_total  <= OUT_STAT_W'(exit_cnt_d);
			rsp_q.rejected_total <= OUT_STAT_W'(rej_cnt_d);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.active_now     = rsp_q.active_now;
	assign rsp.reject         = rsp_q.reject;
	assign rsp.drain_request  = rsp_q.drain_request;
	assign rsp.clear_reason   = rsp_q.clear_reason;
	assign rsp.held_ns        = rsp_q.held_ns;
	assign rsp.armed_now      = rsp_q.armed_now;
	assign rsp.entered_total  = rsp_q.entered_total;
	assign rsp.cleared_total  = rsp_q.cleared_total;
	assign rsp.rejected_total = rsp_q.rejected_total;

	// The latch is consumed on entry and only re-armed while inactive.
	a_active_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !armed_q)
		else $error("watchdog active while re-arm latch is set");

	a_drain_enters: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.drain_request |-> rsp_q.active_now)
		else $error("drain request without active state");

	a_clear_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.clear_reason != CLR_NONE |-> !rsp_q.active_now)
		else $error("clear reported while still active");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && drain_d |=> entry_cnt_q == $past(entry_cnt_q) + 1'b1)
		else $error("entry counter did not follow an entry");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(active_q) && $stable(armed_q))
		else $error("watchdog state changed without an item");

endmodule

// ===== test/tb_stall_backpressure_watchdog.sv =====
`timescale 1ns / 1ps

module tb_stall_backpressure_watchdog;
	import sbw_pkg::*;

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOID_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VOID_B = 3'd7;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam int CYCLE_LIMIT = 500000;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 118;
	localparam int MAX_PRINTS = 100;

	typedef struct packed {
		logic [1:0]          action;
		logic [TIME_W-1:0]   stamp;
		logic [CNT_IN_W-1:0] nfl;
		logic [CNT_IN_W-1:0] nq;
		logic                blk;
	} cmd_item_t;

	typedef struct {
		cmd_item_t item;
		bit        typed;
		rsp_t      want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	sbw_cfg_if cfg_bus();
	sbw_cmd_if cmd_bus();
	sbw_rsp_if rsp_bus();

	stall_backpressure_watchdog dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Watchdog registers and state as the predictor sees them.
	logic [TIME_W-1:0]     stall_thr;
	logic [TIME_W-1:0]     reject_win;
	logic [WATER_W-1:0]    low_water;
	logic [WATER_W-1:0]    hi_mark;
	logic [IFB_W-1:0]      flight_bytes;
	logic [QEB_W-1:0]      queue_bytes;
	logic [TIME_W-1:0]     last_progress;
	logic [TIME_W-1:0]     entered_at;
	logic                  is_active;
	logic                  is_armed;
	logic [OUT_STAT_W-1:0] n_entered;
	logic [OUT_STAT_W-1:0] n_cleared;
	logic [OUT_STAT_W-1:0] n_rejected;

	rsp_t     pending_rsp[$];
	dir_row_t dir_rows[$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       stall_left = 0;
	bit       calm = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report(input string msg);
		fail_count++;
		// Keep the log short when the block is badly broken.
		if (fail_count <= MAX_PRINTS)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [TIME_W-1:0] rand_stamp();
		return TIME_W'({$urandom, $urandom});
	endfunction

	// Occasionally sets bits above a register's width; they must be dropped.
	function automatic logic [TIME_W-1:0] noisy(input logic [TIME_W-1:0] v, input int w);
		if (w < TIME_W && $urandom_range(0, 3) == 0)
			v = v | (rand_stamp() << w);
		return v;
	endfunction

	function automatic rsp_t mk_rsp(input logic act, input logic rej, input logic drn,
			input logic [1:0] why, input logic [TIME_W-1:0] held, input logic arm,
			input logic [OUT_STAT_W-1:0] ent, input logic [OUT_STAT_W-1:0] clr,
			input logic [OUT_STAT_W-1:0] rjt);
		rsp_t r;
		r.active_now = act;
		r.reject = rej;
		r.drain_request = drn;
		r.clear_reason = why;
		r.held_ns = held;
		r.armed_now = arm;
		r.entered_total = ent;
		r.cleared_total = clr;
		r.rejected_total = rjt;
		return r;
	endfunction

	// Advances the watchdog state by one item and returns the status it reports.
	function automatic rsp_t step_watchdog(input cmd_item_t it);
		rsp_t              r;
		logic              ahead;
		logic              after_entry;
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] active_span;
		logic [63:0]       backlog;
		r = '0;
		case (it.action)
			ACT_TICK: begin
				ahead = it.stamp >= last_progress;
				since = ahead ? it.stamp - last_progress : '0;
				backlog = 64'(it.nfl) * 64'(flight_bytes) + 64'(it.nq) * 64'(queue_bytes);
				if (!is_active) begin
					if (backlog < 64'(low_water))
						is_armed = 1'b1;
					if (ahead && since > stall_thr && backlog > 64'(hi_mark) && is_armed) begin
						is_active = 1'b1;
						is_armed = 1'b0;
						entered_at = it.stamp;
						n_entered++;
						r.drain_request = 1'b1;
					end
				end else begin
					after_entry = it.stamp >= entered_at;
					active_span = after_entry ? it.stamp - entered_at : '0;
					if (!ahead || since < stall_thr)
						r.clear_reason = CLR_PROGRESS;
					else if (after_entry && active_span >= reject_win)
						r.clear_reason = CLR_COOLDOWN;
					if (r.clear_reason != CLR_NONE) begin
						is_active = 1'b0;
						n_cleared++;
						r.held_ns = active_span;
					end
				end
			end
			ACT_PROGRESS: last_progress = it.stamp;
			ACT_QUERY: begin
				if (is_active && it.blk) begin
					r.reject = 1'b1;
					n_rejected++;
				end
			end
			default: ;
		endcase
		r.active_now = is_active;
		r.armed_now = is_armed;
		r.entered_total = n_entered;
		r.cleared_total = n_cleared;
		r.rejected_total = n_rejected;
		return r;
	endfunction

	task automatic push_cmd(input cmd_item_t it, input bit typed, input rsp_t want);
		int   gap;
		rsp_t guess;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_bus.action = it.action;
		cmd_bus.timestamp = it.stamp;
		cmd_bus.in_flight_count = it.nfl;
		cmd_bus.queued_count = it.nq;
		cmd_bus.block_work_cmd = it.blk;
		cmd_bus.valid = 1'b1;
		do @(posedge clk); while (!cmd_bus.ready);
		guess = step_watchdog(it);
		pending_rsp.push_back(typed ? want : guess);
	endtask

	task automatic add_row(input logic [1:0] a, input logic [TIME_W-1:0] s,
			input logic [CNT_IN_W-1:0] f, input logic [CNT_IN_W-1:0] q, input logic b,
			input bit typed, input rsp_t want);
		dir_row_t row;
		row.item.action = a;
		row.item.stamp = s;
		row.item.nfl = f;
		row.item.nq = q;
		row.item.blk = b;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
		@(negedge clk);
		cfg_bus.index = idx;
		cfg_bus.data = value;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_STALL_THR:  stall_thr = value;
			REG_REJ_WINDOW: reject_win = value;
			REG_LOW_WATER:  low_water = value[WATER_W-1:0];
			REG_HIGH_WATER: hi_mark = value[WATER_W-1:0];
			REG_IFB:        flight_bytes = value[IFB_W-1:0];
			REG_QEB:        queue_bytes = value[QEB_W-1:0];
			default: ;
		endcase
	endtask

	// Stops sending and waits until every outstanding item has produced its result.
	task automatic drain_wait();
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int p);
		logic [TIME_W-1:0]  thr;
		logic [TIME_W-1:0]  win;
		logic [WATER_W-1:0] lo;
		logic [WATER_W-1:0] hi;
		logic [IFB_W-1:0]   fb;
		logic [QEB_W-1:0]   qb;
		case (p)
			0: begin
				thr = '0;
				win = '0;
				lo = '0;
				hi = '0;
				fb = IFB_W'($urandom_range(1, 4096));
				qb = QEB_W'($urandom_range(0, 64));
			end
			1: begin
				thr = '1;
				win = '1;
				lo = '1;
				hi = '1;
				fb = '1;
				qb = '1;
			end
			default: begin
				thr = TIME_W'($urandom_range(0, 2000));
				win = TIME_W'($urandom_range(0, 3000));
				fb = IFB_W'($urandom_range(1, 4096));
				qb = QEB_W'($urandom_range(0, 256));
				lo = WATER_W'(fb * $urandom_range(0, 2000));
				hi = lo + WATER_W'(fb * $urandom_range(0, 2000));
			end
		endcase
		write_reg(REG_STALL_THR, noisy(thr, TIME_W));
		write_reg(REG_REJ_WINDOW, noisy(win, TIME_W));
		write_reg(REG_LOW_WATER, noisy(TIME_W'(lo), WATER_W));
		write_reg(REG_HIGH_WATER, noisy(TIME_W'(hi), WATER_W));
		write_reg(REG_IFB, noisy(TIME_W'(fb), IFB_W));
		write_reg(REG_QEB, noisy(TIME_W'(qb), QEB_W));
		write_reg((p % 2) ? REG_VOID_A : REG_VOID_B, rand_stamp());
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Random traffic: ticks around the water marks, with stretches free of progress
	// notes so that stalls build up, plus a few time jumps and steps backwards.
	task automatic run_phase(input int p);
		logic [TIME_W-1:0] scale;
		logic [TIME_W-1:0] cur;
		logic [63:0]       lim;
		cmd_item_t         it;
		rsp_t              none;
		bit                stalling;
		int                r;
		none = '0;
		stalling = 1'b0;
		scale = (p < 2) ? TIME_W'(1000) : ((stall_thr > reject_win) ? stall_thr : reject_win) + 16;
		cur = (p % 2) ? rand_stamp() : TIME_W'($urandom_range(0, 100000));
		lim = (flight_bytes == 0) ? 64'd64 : 64'(hi_mark) / 64'(flight_bytes) * 2 + 8;
		if (lim > 64'd65535)
			lim = 64'd65535;
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (k % 24 == 0) begin
				stalling = ($urandom_range(0, 1) != 0);
				calm = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				cur = cur - TIME_W'($urandom_range(0, 32'(scale)));
			else if (r < 8)
				cur = cur + scale * TIME_W'($urandom_range(2, 6));
			else
				cur = cur + TIME_W'($urandom_range(0, 32'(scale) / 4));
			it.stamp = cur;
			it.blk = ($urandom_range(0, 1) != 0);
			it.nfl = CNT_IN_W'($urandom);
			it.nq = CNT_IN_W'($urandom);
			r = $urandom_range(0, 99);
			if (r < 55 || (r < 72 && stalling)) begin
				it.action = ACT_TICK;
				r = $urandom_range(0, 99);
				if (r < 15)
					it.nfl = CNT_IN_W'($urandom_range(0, 32'(lim / 8)));
				else if (r < 85)
					it.nfl = CNT_IN_W'($urandom_range(0, 32'(lim)));
				if ($urandom_range(0, 9) != 0)
					it.nq = CNT_IN_W'($urandom_range(0, 255));
			end else if (r < 72) begin
				it.action = ACT_PROGRESS;
			end else if (r < 94) begin
				it.action = ACT_QUERY;
			end else begin
				it.action = ACT_UNKNOWN;
			end
			push_cmd(it, 1'b0, none);
		end
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_bus.ready = 1'b0;
		end else begin
			rsp_bus.ready = 1'b1;
			if (!calm && $urandom_range(0, 4) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : take_result
		rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_rsp.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				want = pending_rsp.pop_front();
				check_field("active_now", 64'(rsp_bus.active_now), 64'(want.active_now));
				check_field("reject", 64'(rsp_bus.reject), 64'(want.reject));
				check_field("drain_request", 64'(rsp_bus.drain_request),
					64'(want.drain_request));
				check_field("clear_reason", 64'(rsp_bus.clear_reason), 64'(want.clear_reason));
				check_field("held_ns", 64'(rsp_bus.held_ns), 64'(want.held_ns));
				check_field("armed_now", 64'(rsp_bus.armed_now), 64'(want.armed_now));
				check_field("entered_total", 64'(rsp_bus.entered_total),
					64'(want.entered_total));
				check_field("cleared_total", 64'(rsp_bus.cleared_total),
					64'(want.cleared_total));
				check_field("rejected_total", 64'(rsp_bus.rejected_total),
					64'(want.rejected_total));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		rsp_t idle;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = ACT_TICK;
		cmd_bus.timestamp = '0;
		cmd_bus.in_flight_count = '0;
		cmd_bus.queued_count = '0;
		cmd_bus.block_work_cmd = 1'b0;

		stall_thr = RST_STALL_THR;
		reject_win = RST_REJ_WINDOW;
		low_water = RST_LOW_WATER;
		hi_mark = RST_HIGH_WATER;
		flight_bytes = RST_IFB;
		queue_bytes = RST_QEB;
		last_progress = '0;
		entered_at = '0;
		is_active = 1'b0;
		is_armed = 1'b1;
		n_entered = '0;
		n_cleared = '0;
		n_rejected = '0;

		// Reset settings: 60 s stall threshold, 30 s window, 1 MiB per request in flight.
		idle = mk_rsp(0, 0, 0, CLR_NONE, '0, 1, 0, 0, 0);
		add_row(ACT_QUERY, '0, 0, 0, 1, 1, idle);
		add_row(ACT_TICK, '0, 0, 0, 0, 1, idle);
		add_row(ACT_UNKNOWN, 63'd5, 16'hFFFF, 16'hFFFF, 1, 1, idle);
		add_row(ACT_TICK, 63'd60000000001, 200, 0, 0, 1,
			mk_rsp(1, 0, 1, CLR_NONE, '0, 0, 1, 0, 0));
		add_row(ACT_QUERY, 63'd60000000001, 0, 0, 0, 1,
			mk_rsp(1, 0, 0, CLR_NONE, '0, 0, 1, 0, 0));
		add_row(ACT_QUERY, 63'd60000000001, 0, 0, 1, 1,
			mk_rsp(1, 1, 0, CLR_NONE, '0, 0, 1, 0, 1));
		add_row(ACT_TICK, 63'd90000000001, 200, 0, 0, 1,
			mk_rsp(0, 0, 0, CLR_COOLDOWN, 63'd30000000000, 0, 1, 1, 1));
		// Latch still consumed, then re-armed by an empty backlog.
		add_row(ACT_TICK, 63'd90000000001, 200, 0, 0, 0, idle);
		add_row(ACT_TICK, 63'd90000000001, 0, 0, 0, 0, idle);
		add_row(ACT_TICK, 63'd90000000002, 16'hFFFF, 16'hFFFF, 0, 0, idle);
		add_row(ACT_PROGRESS, 63'd90000000010, 0, 0, 0, 0, idle);
		add_row(ACT_TICK, 63'd90000000011, 16'hFFFF, 0, 1, 0, idle);
		add_row(ACT_TICK, 63'd90000000011, 0, 0, 0, 0, idle);
		add_row(ACT_TICK, TIME_MAX, 16'hFFFF, 16'hFFFF, 0, 0, idle);
		add_row(ACT_QUERY, TIME_MAX, 16'hFFFF, 16'hFFFF, 1, 0, idle);
		// Time running backwards while active counts as progress resumed.
		add_row(ACT_TICK, 63'd100, 16'hFFFF, 16'hFFFF, 0, 0, idle);
		add_row(ACT_PROGRESS, TIME_MAX, 0, 0, 0, 0, idle);
		add_row(ACT_TICK, TIME_MAX - 1, 0, 0, 0, 0, idle);
		add_row(ACT_UNKNOWN, '0, 0, 0, 0, 0, idle);
		add_row(ACT_PROGRESS, '0, 0, 0, 1, 0, idle);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			push_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_wait();
			configure(p);
			run_phase(p);
		end
		drain_wait();

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
